### rtl/core/rgbl_pkg.sv
// rgbl_pkg: shared widths, fixed-point constants and the cube-root table builder
// for the RGB to CIELAB pixel pipeline. No dependencies.
package rgbl_pkg;

    localparam int OUT_FRAC_BITS      = 6;
    localparam int CBRT_TABLE_ENTRIES = 1024;

    localparam int CH_W  = 8;
    localparam int T_W   = 18;
    localparam int F_W   = 17;
    localparam int IDX_W = $clog2(CBRT_TABLE_ENTRIES + 1);
    localparam int POS_W = T_W + IDX_W;

    localparam int L_W  = OUT_FRAC_BITS + 8;
    localparam int AB_W = OUT_FRAC_BITS + 9;

    localparam logic [T_W-1:0] COEF_XR = T_W'(284);
    localparam logic [T_W-1:0] COEF_XG = T_W'(247);
    localparam logic [T_W-1:0] COEF_XB = T_W'(124);
    localparam logic [T_W-1:0] COEF_YR = T_W'(139);
    localparam logic [T_W-1:0] COEF_YG = T_W'(469);
    localparam logic [T_W-1:0] COEF_YB = T_W'(47);
    localparam logic [T_W-1:0] COEF_ZR = T_W'(12);
    localparam logic [T_W-1:0] COEF_ZG = T_W'(72);
    localparam logic [T_W-1:0] COEF_ZB = T_W'(572);

    localparam logic [T_W-1:0] KNEE = T_W'(580);
    localparam int KNEE_W     = 10;
    localparam int LIN_PROD_W = 30;
    localparam logic [LIN_PROD_W-1:0] LIN_SLOPE  = LIN_PROD_W'(510333);
    localparam logic [LIN_PROD_W-1:0] LIN_HALF   = LIN_PROD_W'(32768);
    localparam logic [F_W-1:0]        LIN_OFFSET = F_W'(9039);

    localparam int IP_W = F_W + T_W + 1;
    localparam logic [IP_W-1:0] IP_HALF = IP_W'(1) << (T_W - 1);

    localparam int V_W       = 28;
    localparam int SHIFT_OUT = 16 - OUT_FRAC_BITS;
    localparam logic signed [V_W-1:0] L_MUL   = V_W'(116);
    localparam logic signed [V_W-1:0] A_MUL   = V_W'(500);
    localparam logic signed [V_W-1:0] B_MUL   = V_W'(200);
    localparam logic signed [V_W-1:0] L_OFS   = V_W'(16 << 16);
    localparam logic signed [V_W-1:0] RND_HALF = V_W'(1 << (SHIFT_OUT - 1));
    localparam logic signed [V_W-1:0] L_MAX   = V_W'(144 << OUT_FRAC_BITS);
    localparam logic signed [V_W-1:0] AB_MAX  = V_W'((256 << OUT_FRAC_BITS) - 1);
    localparam logic signed [V_W-1:0] AB_MIN  = -V_W'(256 << OUT_FRAC_BITS);

    localparam int STAGES = 6;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    function automatic logic [F_W-1:0] icbrt_round(logic [63:0] q);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] d;
        lo = 64'd0;
        hi = 64'd1 << 18;
        while (hi - lo > 64'd1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid * mid <= q)
                lo = mid;
            else
                hi = mid;
        end
        d = 64'd2 * lo + 64'd1;
        if (d * d * d <= 64'd8 * q)
            lo = lo + 64'd1;
        return lo[F_W-1:0];
    endfunction

endpackage

### rtl/core/rgbl_rgb_if.sv
// rgbl_rgb_if: valid/ready channel carrying one RGB pixel.
// Depends on rgbl_pkg for the channel width.
interface rgbl_rgb_if;
    import rgbl_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

### rtl/core/rgbl_lab_if.sv
// rgbl_lab_if: valid/ready channel carrying one CIELAB result.
// Depends on rgbl_pkg for the field widths.
interface rgbl_lab_if;
    import rgbl_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [L_W-1:0]         lightness;
    logic signed [AB_W-1:0] green_red_axis;
    logic signed [AB_W-1:0] blue_yellow_axis;

    modport source (output valid, output lightness, output green_red_axis,
                    output blue_yellow_axis, input ready);
    modport sink   (input valid, input lightness, input green_red_axis,
                    input blue_yellow_axis, output ready);
endinterface

### rtl/core/rgbl_lab_f.sv
// rgbl_lab_f: three-stage CIELAB f(t) for one channel: table lookup,
// interpolation product, knee select. Depends on rgbl_pkg.
module rgbl_lab_f
    import rgbl_pkg::*;
(
    input  logic            clk,
    input  stage_en_t       en,
    input  logic [T_W-1:0]  t,
    output logic [F_W-1:0]  f
);

    logic [F_W-1:0]        cbrt_rom [0:CBRT_TABLE_ENTRIES];

    logic [POS_W-1:0]      pos;
    logic [IDX_W-1:0]      idx;
    logic [IDX_W-1:0]      idx_hi;
    logic [T_W-1:0]        fr;

    logic [F_W-1:0]        lo_reg;
    logic [F_W-1:0]        hi_reg;
    logic [T_W-1:0]        fr_reg;
    logic                  knee_reg;
    logic [LIN_PROD_W-1:0] lin_prod_reg;

    logic [F_W-1:0]        diff;
    logic [LIN_PROD_W-1:0] lin_round;
    logic [F_W-1:0]        lin_f;

    logic [IP_W-1:0]       ip_prod_reg;
    logic [F_W-1:0]        lo3_reg;
    logic [F_W-1:0]        lin_f_reg;
    logic                  knee3_reg;

    logic [IP_W-1:0]       ip_round;
    logic [F_W-1:0]        f_next;
    logic [F_W-1:0]        f_reg;

    for (genvar k = 0; k <= CBRT_TABLE_ENTRIES; k++)
    begin : g_rom
        localparam logic [F_W-1:0] ENTRY =
            icbrt_round((64'(k) << 50) / 64'(CBRT_TABLE_ENTRIES));
        assign cbrt_rom[k] = ENTRY;
    end

    assign pos    = POS_W'(t) * POS_W'(CBRT_TABLE_ENTRIES);
    assign idx    = pos[POS_W-1:T_W];
    assign idx_hi = idx + IDX_W'(1);
    assign fr     = pos[T_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            lo_reg       <= cbrt_rom[idx];
            hi_reg       <= cbrt_rom[idx_hi];
            fr_reg       <= fr;
            knee_reg     <= (t > KNEE);
            lin_prod_reg <= LIN_SLOPE * LIN_PROD_W'(t[KNEE_W-1:0]);
        end
    end

    assign diff      = hi_reg - lo_reg;
    assign lin_round = lin_prod_reg + LIN_HALF;
    assign lin_f     = F_W'(lin_round >> 16) + LIN_OFFSET;

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            ip_prod_reg <= IP_W'(diff) * IP_W'(fr_reg);
            lo3_reg     <= lo_reg;
            lin_f_reg   <= lin_f;
            knee3_reg   <= knee_reg;
        end
    end

    assign ip_round = ip_prod_reg + IP_HALF;
    assign f_next   = knee3_reg ? (lo3_reg + F_W'(ip_round >> T_W)) : lin_f_reg;

    always_ff @(posedge clk)
    begin
        if (en.s4)
            f_reg <= f_next;
    end

    assign f = f_reg;

endmodule

### rtl/core/rgb_to_lab_pixel.sv
// rgb_to_lab_pixel: RGB byte pixel to CIELAB L, a, b, six-stage pipeline.
// Depends on rgbl_pkg, rgbl_rgb_if, rgbl_lab_if and rgbl_lab_f.
//
//   channel  dir  payload                                           handshake
//   pixel    in   red_in, green_in, blue_in (8 b each)              valid/ready
//   lab      out  lightness (14 b), green_red_axis, blue_yellow_axis  valid/ready
//                 (15 b signed each), 6 fraction bits
//
// One pixel per clock while lab.ready is held; the stages, in order, are the matrix stage,
// the registered cube-root table read, the interpolation multiply, the knee
// select, the L/a/b scaling and the round/saturate output register.
// rst_n clears only the stage valid bits. Each stage holds when its successor
// is full and stalled, so bubbles collapse and ready drops only when full.
module rgb_to_lab_pixel
    import rgbl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rgbl_rgb_if.sink   pixel,
    rgbl_lab_if.source lab
);

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] en;
    stage_en_t         f_en;

    logic [T_W-1:0] tx_reg;
    logic [T_W-1:0] ty_reg;
    logic [T_W-1:0] tz_reg;

    logic [F_W-1:0] fx;
    logic [F_W-1:0] fy;
    logic [F_W-1:0] fz;

    logic signed [V_W-1:0] fx_s;
    logic signed [V_W-1:0] fy_s;
    logic signed [V_W-1:0] fz_s;
    logic signed [V_W-1:0] lv_reg;
    logic signed [V_W-1:0] av_reg;
    logic signed [V_W-1:0] bv_reg;

    logic signed [V_W-1:0] lr;
    logic signed [V_W-1:0] ar;
    logic signed [V_W-1:0] br;
    logic [L_W-1:0]         l_next;
    logic signed [AB_W-1:0] a_next;
    logic signed [AB_W-1:0] b_next;
    logic [L_W-1:0]         l_reg;
    logic signed [AB_W-1:0] a_reg;
    logic signed [AB_W-1:0] b_reg;

    always_comb
    begin
        en[STAGES-1] = !vld_reg[STAGES-1] || lab.ready;
        for (int i = STAGES - 2; i >= 0; i--)
            en[i] = !vld_reg[i] || en[i+1];
    end

    assign pixel.ready = en[0];
    assign f_en.s2 = en[1];
    assign f_en.s3 = en[2];
    assign f_en.s4 = en[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= pixel.valid;
            for (int i = 1; i < STAGES; i++)
            begin
                if (en[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            tx_reg <= COEF_XR * T_W'(pixel.red_in) + COEF_XG * T_W'(pixel.green_in)
                    + COEF_XB * T_W'(pixel.blue_in);
            ty_reg <= COEF_YR * T_W'(pixel.red_in) + COEF_YG * T_W'(pixel.green_in)
                    + COEF_YB * T_W'(pixel.blue_in);
            tz_reg <= COEF_ZR * T_W'(pixel.red_in) + COEF_ZG * T_W'(pixel.green_in)
                    + COEF_ZB * T_W'(pixel.blue_in);
        end
    end

    rgbl_lab_f u_fx (.clk(clk), .en(f_en), .t(tx_reg), .f(fx));
    rgbl_lab_f u_fy (.clk(clk), .en(f_en), .t(ty_reg), .f(fy));
    rgbl_lab_f u_fz (.clk(clk), .en(f_en), .t(tz_reg), .f(fz));

    assign fx_s = V_W'(fx);
    assign fy_s = V_W'(fy);
    assign fz_s = V_W'(fz);

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            lv_reg <= L_MUL * fy_s - L_OFS;
            av_reg <= A_MUL * (fx_s - fy_s);
            bv_reg <= B_MUL * (fy_s - fz_s);
        end
    end

    assign lr = (lv_reg + RND_HALF) >>> SHIFT_OUT;
    assign ar = (av_reg + RND_HALF) >>> SHIFT_OUT;
    assign br = (bv_reg + RND_HALF) >>> SHIFT_OUT;

    always_comb
    begin
        if (lr < 0)
            l_next = '0;
        else if (lr > L_MAX)
            l_next = L_MAX[L_W-1:0];
        else
            l_next = lr[L_W-1:0];

        if (ar < AB_MIN)
            a_next = AB_MIN[AB_W-1:0];
        else if (ar > AB_MAX)
            a_next = AB_MAX[AB_W-1:0];
        else
            a_next = ar[AB_W-1:0];

        if (br < AB_MIN)
            b_next = AB_MIN[AB_W-1:0];
        else if (br > AB_MAX)
            b_next = AB_MAX[AB_W-1:0];
        else
            b_next = br[AB_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            l_reg <= l_next;
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign lab.valid            = vld_reg[STAGES-1];
    assign lab.lightness        = l_reg;
    assign lab.green_red_axis   = a_reg;
    assign lab.blue_yellow_axis = b_reg;

endmodule

### tb/sv/rgb_to_lab_pixel_tb.sv
// rgb_to_lab_pixel_tb: self-checking bench for the RGB to CIELAB pixel pipeline.
// Depends on rgbl_pkg, rgbl_rgb_if, rgbl_lab_if and rgb_to_lab_pixel; drives
// directed then random pixels, predicts L, a, b in fixed point and checks each item.
module rgb_to_lab_pixel_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbl_pkg::*;

    localparam int    CLK_PERIOD    = 12;
    localparam int    RESET_CYCLES  = 7;
    localparam int    RANDOM_ITEMS  = 2000;
    localparam int    IDLE_LIMIT    = 4000;
    localparam int    DRAIN_CYCLES  = 30;
    localparam int    HOLD_AFTER    = 400;
    localparam int    HOLD_CYCLES   = 150;
    localparam int    REPORT_LIMIT  = 10;
    localparam int    DIRECTED_N    = 21;

    localparam longint unsigned RATIO_BITS    = 18;
    localparam longint unsigned RATIO_LIMIT   = 64'd1 << RATIO_BITS;
    localparam longint unsigned KNEE_RATIO    = 580;
    localparam longint unsigned LINEAR_SLOPE  = 510333;
    localparam longint unsigned LINEAR_OFFSET = 9039;
    localparam int              OUT_SHIFT     = 16 - OUT_FRAC_BITS;
    localparam longint          L_TOP         = longint'(144) << OUT_FRAC_BITS;
    localparam longint          AXIS_TOP      = (longint'(256) << OUT_FRAC_BITS) - 1;
    localparam longint          AXIS_BOTTOM   = -(longint'(256) << OUT_FRAC_BITS);

    typedef struct {
        logic [L_W-1:0]         lightness;
        logic signed [AB_W-1:0] green_red;
        logic signed [AB_W-1:0] blue_yellow;
    } lab_value_t;

    typedef struct {
        logic [CH_W-1:0]        r;
        logic [CH_W-1:0]        g;
        logic [CH_W-1:0]        b;
        bit                     typed;
        logic [L_W-1:0]         lightness;
        logic signed [AB_W-1:0] green_red;
        logic signed [AB_W-1:0] blue_yellow;
    } pixel_row_t;

    logic clk;
    logic rst_n;

    rgbl_rgb_if pixel ();
    rgbl_lab_if lab ();

    rgb_to_lab_pixel u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel),
        .lab   (lab)
    );

    longint unsigned cube_root_lut [0:CBRT_TABLE_ENTRIES];
    lab_value_t      expected_lab [$];
    pixel_row_t      directed_rows [DIRECTED_N];
    int              error_count  = 0;
    int              results_seen = 0;
    int              idle_cycles  = 0;
    bit              src_calm     = 1'b0;
    bit              sink_calm    = 1'b0;
    bit              held_off     = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2.0) clk = ~clk;
        end
    end

    function automatic longint unsigned nearest_cube_root(longint unsigned q);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned odd;
        lo = 0;
        hi = 64'd1 << 18;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if (mid * mid * mid <= q)
                lo = mid;
            else
                hi = mid;
        end
        odd = 2 * lo + 1;
        if (odd * odd * odd <= 8 * q)
            lo = lo + 1;
        return lo;
    endfunction

    function automatic longint unsigned lab_curve(longint unsigned t);
        longint unsigned pos;
        longint unsigned idx;
        longint unsigned fr;
        longint unsigned lo;
        longint unsigned hi;
        if (t > KNEE_RATIO)
        begin
            if (t >= RATIO_LIMIT)
                t = RATIO_LIMIT - 1;
            pos = t * CBRT_TABLE_ENTRIES;
            idx = pos >> RATIO_BITS;
            fr  = pos & (RATIO_LIMIT - 1);
            if (idx >= CBRT_TABLE_ENTRIES)
                idx = CBRT_TABLE_ENTRIES - 1;
            lo = cube_root_lut[idx];
            hi = cube_root_lut[idx + 1];
            if (hi < lo)
                hi = lo;
            return lo + (((hi - lo) * fr + (RATIO_LIMIT >> 1)) >> RATIO_BITS);
        end
        return ((LINEAR_SLOPE * t + 32768) >> 16) + LINEAR_OFFSET;
    endfunction

    function automatic longint round_to_out(longint v);
        return (v + (longint'(1) << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    endfunction

    function automatic longint saturate(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic lab_value_t predict_lab(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                               logic [CH_W-1:0] b);
        longint unsigned rr;
        longint unsigned gg;
        longint unsigned bl;
        longint          fx;
        longint          fy;
        longint          fz;
        lab_value_t      res;
        rr = r;
        gg = g;
        bl = b;
        fx = longint'(lab_curve(284 * rr + 247 * gg + 124 * bl));
        fy = longint'(lab_curve(139 * rr + 469 * gg + 47 * bl));
        fz = longint'(lab_curve(12 * rr + 72 * gg + 572 * bl));
        res.lightness   = L_W'(saturate(round_to_out(116 * fy - (longint'(16) << 16)),
                                        0, L_TOP));
        res.green_red   = AB_W'(saturate(round_to_out(500 * (fx - fy)),
                                         AXIS_BOTTOM, AXIS_TOP));
        res.blue_yellow = AB_W'(saturate(round_to_out(200 * (fy - fz)),
                                         AXIS_BOTTOM, AXIS_TOP));
        return res;
    endfunction

    function automatic int idle_gap(bit calm);
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [CH_W-1:0] pick_byte();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return CH_W'($urandom);
        if (roll < 85)
            return CH_W'($urandom_range(0, 6));
        return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    endfunction

    function automatic void flag_error(string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%s", msg);
    endfunction

    task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b, input lab_value_t want);
        int gap;
        gap = idle_gap(src_calm);
        if (gap > 0)
        begin
            pixel.valid = 1'b0;
            repeat (gap)
            begin
                pixel.red_in   = CH_W'($urandom);
                pixel.green_in = CH_W'($urandom);
                pixel.blue_in  = CH_W'($urandom);
                @(negedge clk);
            end
        end
        pixel.valid    = 1'b1;
        pixel.red_in   = r;
        pixel.green_in = g;
        pixel.blue_in  = b;
        do
            @(posedge clk);
        while (!pixel.ready);
        expected_lab.push_back(want);
        @(negedge clk);
    endtask

    initial
    begin
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        lab_value_t      want;

        for (int k = 0; k <= CBRT_TABLE_ENTRIES; k++)
            cube_root_lut[k] = nearest_cube_root((longint'(k) << 50) / CBRT_TABLE_ENTRIES);

        directed_rows = '{
            '{8'h00, 8'h00, 8'h00, 1'b1, 14'd0, 15'sd0, 15'sd0},
            '{8'hFF, 8'hFF, 8'hFF, 1'b0, 14'd0, 15'sd0, 15'sd0},
            '{8'hFF, 8'h00, 8'h00, 1'b0, 14'd0, 15'sd0, 15'sd0},
            '{8'h00, 8'hFF, 8'h00, 1'b0, 14'd0, 15'sd0, 15'sd0},
            '{8'h00, 8'h00, 8'hFF, 1'b0, 14'd0, 15'sd0, 15'sd0},
            '{8'hFF, 8'hFF, 8'h00, 1'b0, 14'd0, 15'sd0, 15'sd0},
            '{8'h00, 8'hFF, 8'hFF, 1'b0, 14'd0, 15'sd0, 15'sd0},
            '{8'hFF, 8'h00, 8'hFF, 1'b0, 14'd0, 15'sd0, 15'sd0},
            '{8'h01, 8'h00, 8'h00, 1'b0, 14'd0, 15'sd0, 15'sd0},
            '{8'h00, 8'h01, 8'h00, 1'b0, 14'd0, 15'sd0, 15'sd0},
            '{8'h00, 8'h00, 8'h01, 1'b0, 14'd0, 15'sd0, 15'sd0},
            '{8'h02, 8'h00, 8'h00, 1'b0, 14'd0, 15'sd0, 15'sd0},
            '{8'h03, 8'h00, 8'h00, 1'b0, 14'd0, 15'sd0, 15'sd0},
            '{8'h04, 8'h00, 8'h00, 1'b0, 14'd0, 15'sd0, 15'sd0},
            '{8'h05, 8'h00, 8'h00, 1'b0, 14'd0, 15'sd0, 15'sd0},
            '{8'h00, 8'h02, 8'h00, 1'b0, 14'd0, 15'sd0, 15'sd0},
            '{8'h00, 8'h00, 8'h02, 1'b0, 14'd0, 15'sd0, 15'sd0},
            '{8'h55, 8'hAA, 8'h80, 1'b0, 14'd0, 15'sd0, 15'sd0},
            '{8'hAA, 8'h55, 8'h7F, 1'b0, 14'd0, 15'sd0, 15'sd0},
            '{8'h7F, 8'h80, 8'hFE, 1'b0, 14'd0, 15'sd0, 15'sd0},
            '{8'hFE, 8'h01, 8'h80, 1'b0, 14'd0, 15'sd0, 15'sd0}
        };

        rst_n          = 1'b0;
        pixel.valid    = 1'b0;
        pixel.red_in   = '0;
        pixel.green_in = '0;
        pixel.blue_in  = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].typed)
            begin
                want.lightness   = directed_rows[i].lightness;
                want.green_red   = directed_rows[i].green_red;
                want.blue_yellow = directed_rows[i].blue_yellow;
            end
            else
                want = predict_lab(directed_rows[i].r, directed_rows[i].g, directed_rows[i].b);
            send_pixel(directed_rows[i].r, directed_rows[i].g, directed_rows[i].b, want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                src_calm = ($urandom_range(0, 3) == 0);
            r = pick_byte();
            g = pick_byte();
            b = pick_byte();
            send_pixel(r, g, b, predict_lab(r, g, b));
        end
        pixel.valid = 1'b0;

        while (expected_lab.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("rgb_to_lab_pixel_tb: clean");
        else
            $display("rgb_to_lab_pixel_tb: errors");
        $finish;
    end

    initial
    begin
        int gap;
        int burst;
        lab.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && results_seen >= HOLD_AFTER)
            begin
                held_off  = 1'b1;
                lab.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            gap = idle_gap(sink_calm);
            if (gap > 0)
            begin
                lab.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            lab.ready = 1'b1;
            burst = $urandom_range(1, 12);
            repeat (burst - 1) @(negedge clk);
            if ($urandom_range(0, 15) == 0)
                sink_calm = !sink_calm;
        end
    end

    always @(posedge clk)
    begin
        lab_value_t want;
        if (rst_n && lab.valid && lab.ready)
        begin
            results_seen++;
            if (expected_lab.size() == 0)
                flag_error($sformatf("unexpected item: L=%0d a=%0d b=%0d",
                                     lab.lightness, lab.green_red_axis, lab.blue_yellow_axis));
            else
            begin
                want = expected_lab.pop_front();
                if (lab.lightness !== want.lightness || lab.green_red_axis !== want.green_red
                    || lab.blue_yellow_axis !== want.blue_yellow)
                    flag_error($sformatf(
                        "item %0d mismatch: expected L=%0d a=%0d b=%0d, got L=%0d a=%0d b=%0d",
                        results_seen, want.lightness, want.green_red, want.blue_yellow,
                        lab.lightness, lab.green_red_axis, lab.blue_yellow_axis));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel.valid && pixel.ready) || (lab.valid && lab.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("rgb_to_lab_pixel_tb: errors");
                $finish;
            end
        end
    end

endmodule
